// File: hw/rtl/t2rf_pkg.sv
// shared constants, types and codes for the 2d tile replicate and fold block
package t2rf_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int MAX_REPS    = 256;

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int SUM_W    = 48;
  localparam int SIZE_W   = 11;
  localparam int SIZE_MAX = 1024;
  localparam int POS_W    = 10;
  localparam int REPF_W   = 9;
  localparam int REPC_W   = $clog2(MAX_REPS + 1);
  localparam int REP_W    = $clog2(MAX_REPS);
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_EMIT  = 2'd1,
    KIND_ACCUM = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ROWS_SRC = 2'd0,
    REG_COLS_SRC = 2'd1,
    REG_REP_ROWS = 2'd2,
    REG_REP_COLS = 2'd3
  } reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [REPC_W-1:0] rep_rows;
    logic [REPC_W-1:0] rep_cols;
  } cfg_t;

endpackage

// File: hw/rtl/t2rf_if.sv
// item and result channel interfaces
interface t2rf_in_if import t2rf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, kind, value, index, input ready);
  modport sink (input valid, kind, value, index, output ready);
endinterface

interface t2rf_out_if import t2rf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] data;
  logic                    last;

  modport source (output valid, data, last, input ready);
  modport sink (input valid, data, last, output ready);
endinterface

// File: hw/rtl/t2rf_ram.sv
// generic single write port ram with registered read
module t2rf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/t2rf_cfg.sv
// apb configuration registers with range clamping
module t2rf_cfg import t2rf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              restart
);

  reg_t sel;
  logic wr;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > 32'(SIZE_MAX)) begin
      r = SIZE_W'(SIZE_MAX);
    end
    return r;
  endfunction

  function automatic logic [REPC_W-1:0] clamp_rep(input logic [REPF_W-1:0] v);
    logic [REPC_W-1:0] r;
    r = REPC_W'(v);
    if (v == '0) begin
      r = REPC_W'(1);
    end else if (32'(v) > 32'(MAX_REPS)) begin
      r = REPC_W'(MAX_REPS);
    end
    return r;
  endfunction

  assign sel     = reg_t'(paddr[3:2]);
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows     <= SIZE_W'(1);
      cfg.cols     <= SIZE_W'(1);
      cfg.rep_rows <= REPC_W'(1);
      cfg.rep_cols <= REPC_W'(1);
    end else if (wr) begin
      unique case (sel)
        REG_ROWS_SRC: cfg.rows     <= clamp_size(pwdata[SIZE_W-1:0]);
        REG_COLS_SRC: cfg.cols     <= clamp_size(pwdata[SIZE_W-1:0]);
        REG_REP_ROWS: cfg.rep_rows <= clamp_rep(pwdata[REPF_W-1:0]);
        REG_REP_COLS: cfg.rep_cols <= clamp_rep(pwdata[REPF_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_ROWS_SRC: prdata = CFG_DW'(cfg.rows);
      REG_COLS_SRC: prdata = CFG_DW'(cfg.cols);
      REG_REP_ROWS: prdata = CFG_DW'(cfg.rep_rows);
      REG_REP_COLS: prdata = CFG_DW'(cfg.rep_cols);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/t2rf_walk.sv
// tiled raster walk counters with incremental store address
module t2rf_walk import t2rf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              restart,
  input  logic              step,
  output logic [ADDR_W-1:0] addr,
  output logic              last
);

  logic [POS_W-1:0]  src_row;
  logic [POS_W-1:0]  src_col;
  logic [REP_W-1:0]  tile_row;
  logic [REP_W-1:0]  tile_col;
  logic [ADDR_W-1:0] row_base;
  logic              col_end;
  logic              tcol_end;
  logic              row_end;
  logic              trow_end;

  assign col_end  = SIZE_W'(src_col) == cfg.cols - SIZE_W'(1);
  assign row_end  = SIZE_W'(src_row) == cfg.rows - SIZE_W'(1);
  assign tcol_end = REPC_W'(tile_col) == cfg.rep_cols - REPC_W'(1);
  assign trow_end = REPC_W'(tile_row) == cfg.rep_rows - REPC_W'(1);
  assign last     = col_end && row_end && tcol_end && trow_end;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      src_row  <= '0;
      src_col  <= '0;
      tile_row <= '0;
      tile_col <= '0;
      row_base <= '0;
      addr     <= '0;
    end else if (step) begin
      if (!col_end) begin
        src_col <= src_col + 1'b1;
        addr    <= addr + 1'b1;
      end else begin
        src_col <= '0;
        if (!tcol_end) begin
          tile_col <= tile_col + 1'b1;
          addr     <= row_base;
        end else begin
          tile_col <= '0;
          if (!row_end) begin
            src_row  <= src_row + 1'b1;
            row_base <= row_base + ADDR_W'(cfg.cols);
            addr     <= row_base + ADDR_W'(cfg.cols);
          end else begin
            src_row  <= '0;
            row_base <= '0;
            addr     <= '0;
            tile_row <= trow_end ? '0 : tile_row + 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/tile_2d_replicate_and_fold_core.sv
// top level: tile emit and gradient fold over source and sum memories
// path: an accepted word is held in the b stage, and its emit or read result is then registered in the output stage
// throughput: one word per cycle while results are taken; the memory
//   read at acceptance and the write back from the b stage set this pace
// reset: registers return to 1, walks to the raster start, and the sum
//   memory is cleared entry by entry, during which no word is taken
module tile_2d_replicate_and_fold_core import t2rf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  t2rf_in_if.sink           item,
  t2rf_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int SUM_W1 = SUM_W + 1;

  cfg_t  cfg;
  logic  restart;
  kind_t in_kind;
  logic  accept;

  logic [ADDR_W-1:0] emit_addr;
  logic [ADDR_W-1:0] grad_addr;
  logic              emit_last;
  logic              grad_last;
  logic [ADDR_W-1:0] in_addr;

  logic               src_wr_en;
  logic [ADDR_W-1:0]  src_wr_addr;
  logic [VALUE_W-1:0] src_wr_data;
  logic [VALUE_W-1:0] src_rd_data;
  logic [ADDR_W-1:0]  src_rd_addr;

  logic              sum_wr_en;
  logic [ADDR_W-1:0] sum_wr_addr;
  logic [SUM_W-1:0]  sum_wr_data;
  logic [SUM_W-1:0]  sum_rd_data;
  logic [ADDR_W-1:0] sum_rd_addr;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic                      b_valid;
  kind_t                     b_kind;
  logic [ADDR_W-1:0]         b_addr;
  logic signed [VALUE_W-1:0] b_val;
  logic                      b_last;
  logic                      b_fwd_src;
  logic                      b_fwd_sum;
  logic [VALUE_W-1:0]        b_fwd_src_data;
  logic [SUM_W-1:0]          b_fwd_sum_data;
  logic                      b_has_result;
  logic                      b_go;

  logic signed [VALUE_W-1:0] b_src;
  logic signed [SUM_W-1:0]   b_sum;
  logic signed [SUM_W1-1:0]  sum_wide;
  logic [SUM_W-1:0]          sum_sat;

  logic                    o_valid;
  logic signed [SUM_W-1:0] o_data;
  logic                    o_last;

  t2rf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  assign in_kind = kind_t'(item.kind);
  assign accept  = item.valid && item.ready;
  assign in_addr = ADDR_W'(item.index);

  t2rf_walk u_emit_walk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .step    (accept && in_kind == KIND_EMIT),
    .addr    (emit_addr),
    .last    (emit_last)
  );

  t2rf_walk u_grad_walk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .step    (accept && in_kind == KIND_ACCUM),
    .addr    (grad_addr),
    .last    (grad_last)
  );

  assign b_has_result = b_kind == KIND_EMIT || b_kind == KIND_READ;
  assign b_go         = b_valid && (!b_has_result || !o_valid || result.ready);
  assign item.ready   = !clearing && (!b_valid || b_go);

  assign src_rd_addr = emit_addr;
  assign sum_rd_addr = (in_kind == KIND_ACCUM) ? grad_addr : in_addr;

  assign src_wr_en   = b_go && b_kind == KIND_LOAD;
  assign src_wr_addr = b_addr;
  assign src_wr_data = b_val;

  assign sum_wr_en   = clearing || (b_go && (b_kind == KIND_ACCUM || b_kind == KIND_READ));
  assign sum_wr_addr = clearing ? clr_addr : b_addr;
  assign sum_wr_data = (!clearing && b_kind == KIND_ACCUM) ? sum_sat : '0;

  t2rf_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_src_ram (
    .clk     (clk),
    .wr_en   (src_wr_en),
    .wr_addr (src_wr_addr),
    .wr_data (src_wr_data),
    .rd_en   (accept),
    .rd_addr (src_rd_addr),
    .rd_data (src_rd_data)
  );

  t2rf_ram #(.WIDTH(SUM_W), .DEPTH(STORE_DEPTH)) u_sum_ram (
    .clk     (clk),
    .wr_en   (sum_wr_en),
    .wr_addr (sum_wr_addr),
    .wr_data (sum_wr_data),
    .rd_en   (accept),
    .rd_addr (sum_rd_addr),
    .rd_data (sum_rd_data)
  );

  // forwarded data covers a write back to the entry being read
  assign b_src = b_fwd_src ? b_fwd_src_data : src_rd_data;
  assign b_sum = b_fwd_sum ? b_fwd_sum_data : sum_rd_data;

  assign sum_wide = SUM_W1'(b_sum) + SUM_W1'(b_val);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_kind         <= in_kind;
      b_val          <= item.value;
      b_addr         <= (in_kind == KIND_ACCUM) ? grad_addr : in_addr;
      b_last         <= (in_kind == KIND_EMIT) && emit_last;
      b_fwd_src      <= src_wr_en && src_wr_addr == src_rd_addr;
      b_fwd_src_data <= src_wr_data;
      b_fwd_sum      <= sum_wr_en && sum_wr_addr == sum_rd_addr;
      b_fwd_sum_data <= sum_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (b_go && b_has_result) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_has_result) begin
      o_data <= (b_kind == KIND_EMIT) ? SUM_W'(b_src) : b_sum;
      o_last <= b_last;
    end
  end

  assign result.valid = o_valid;
  assign result.data  = o_data;
  assign result.last  = o_last;

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    b_go && b_has_result |=> o_valid)
    else $error("result word lost between stages");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    clearing |-> sum_wr_en && sum_wr_data == '0 && !accept)
    else $error("sum memory clearing disturbed");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == ADDR_W'(STORE_DEPTH - 1))
    else $error("clearing pass ended early");

  a_fwd_kind: assert property (@(posedge clk) disable iff (rst)
    $past(accept) && b_fwd_sum |-> $past(sum_wr_en) && !$past(clearing))
    else $error("sum forward without a write back");

  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_last |-> b_kind == KIND_EMIT)
    else $error("last flag on a non emit word");

endmodule
